// ===== src/waypoint_heading_to_target_unit_macros.svh =====
// Assertion macros for the waypoint heading unit.
// Included by modules that carry concurrent checks; no other dependency.
`ifndef WAYPOINT_HEADING_TO_TARGET_UNIT_MACROS_SVH
`define WAYPOINT_HEADING_TO_TARGET_UNIT_MACROS_SVH
// implication checked every clock, off during reset
`define WHT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define WHT_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== src/wht_pkg.sv =====
// Shared constants, types and arctangent table of the waypoint heading unit.
// No dependencies.
package wht_pkg;
    localparam int COORD_BITS_DEF    = 32;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int MAX_WAYPOINTS_DEF = 256;
    localparam int CORDIC_STEPS      = 30;
    localparam int ZW                = 32;
    // working width of the CORDIC datapath (vector normalized to 2^51)
    localparam int CW                = 56;
    localparam int NORM_EXP          = 51;
    localparam int CFG_IDX_BITS      = 2;
    localparam int CFG_DATA_BITS     = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ROTATE_BUSY   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MOVEMENT_MODE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DISTANCE  = 2'd2;
    localparam logic [1:0] MODE_HEADING = 2'd1;
    localparam logic [15:0] MIN_DIST_RESET = 16'd26;

    // per-request side data carried beside the angle datapath
    typedef struct packed {
        logic       ok;
        logic [7:0] slot;
        logic       last;
    } t_tag;

    function automatic logic [ZW-1:0] atan_turns(input int i);
        logic [ZW-1:0] r;
        r = '0;
        case (i)
            0:  r = 32'd536870912;  1: r = 32'd316933406; 2: r = 32'd167458907;
            3:  r = 32'd85004756;   4: r = 32'd42667331;  5: r = 32'd21354465;
            6:  r = 32'd10679838;   7: r = 32'd5340245;   8: r = 32'd2670163;
            9:  r = 32'd1335087;   10: r = 32'd667544;   11: r = 32'd333772;
            12: r = 32'd166886;    13: r = 32'd83443;    14: r = 32'd41722;
            15: r = 32'd20861;     16: r = 32'd10430;    17: r = 32'd5215;
            18: r = 32'd2608;      19: r = 32'd1304;     20: r = 32'd652;
            21: r = 32'd326;       22: r = 32'd163;      23: r = 32'd81;
            24: r = 32'd41;        25: r = 32'd20;       26: r = 32'd10;
            27: r = 32'd5;         28: r = 32'd3;        29: r = 32'd1;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

// ===== src/waypoint_heading_to_target_unit.sv =====
// Waypoint heading unit: request, output interface, registers and pipeline.
// Uses wht_pkg, wht_front, wht_queue, wht_cordic.
//
// Usage: drive the waypoint, neighbors, target, index and last flag and raise
// start; a request is taken each rising edge with start high and busy
// low. busy is always low, so one request may be issued every cycle.
// Each request yields exactly one result, held on o_heading, o_slot,
// o_written and o_last_out for one cycle with o_done high; results come in
// request order. Each passes the front end (difference, squares, distance
// test), the queue and the CORDIC pipe (pre-rotation, 30 micro-rotations,
// rounding). Throughput is set by the fully pipelined CORDIC unit: one
// request per cycle.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write rotate_busy (0),
// movement_mode (1), min_distance (2); other indexes are ignored.
// Write only while no request is in flight.
// Reset clears the pipeline valids and sets the registers to 0, 0, 26.
// The receiver cannot stall; results are never held.
module waypoint_heading_to_target_unit import wht_pkg::*; #(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_prev_x, i_prev_y,
    input  logic signed [COORD_BITS-1:0] i_here_x, i_here_y,
    input  logic signed [COORD_BITS-1:0] i_next_x, i_next_y,
    input  logic signed [COORD_BITS-1:0] i_target_x, i_target_y,
    input  logic [7:0]                   i_waypoint_index,
    input  logic                         i_last_in,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]     i_cfg_data,
    output logic                         o_done,
    output logic signed [15:0]           o_heading,
    output logic [7:0]                   o_slot,
    output logic                         o_written,
    output logic                         o_last_out
);
    localparam int DW = COORD_BITS + 5;
    localparam int QW = 2 * DW + $bits(t_tag);

    assign busy = 1'b0;

    // configuration registers
    logic        r_rotate_busy;
    logic [1:0]  r_mode;
    logic [15:0] r_min_dist;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotate_busy <= 1'b0;
            r_mode        <= 2'd0;
            r_min_dist    <= MIN_DIST_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROTATE_BUSY:   r_rotate_busy <= i_cfg_data[0];
                REG_MOVEMENT_MODE: r_mode        <= i_cfg_data[1:0];
                REG_MIN_DISTANCE:  r_min_dist    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic                 f_valid, q_valid;
    logic signed [DW-1:0] f_dx, f_dy;
    t_tag                 f_tag, q_tag;
    logic [QW-1:0]        q_data;

    wht_front #(.COORD_BITS(COORD_BITS), .MAX_WAYPOINTS(MAX_WAYPOINTS), .DW(DW)) u_front (
        .i_clk, .i_rst_n, .i_valid(start && !busy),
        .i_px(i_prev_x), .i_py(i_prev_y), .i_hx(i_here_x), .i_hy(i_here_y),
        .i_nx(i_next_x), .i_ny(i_next_y), .i_tx(i_target_x), .i_ty(i_target_y),
        .i_idx(i_waypoint_index), .i_last(i_last_in),
        .i_rotate_busy(r_rotate_busy), .i_mode(r_mode), .i_min_dist(r_min_dist),
        .o_valid(f_valid), .o_dx(f_dx), .o_dy(f_dy), .o_tag(f_tag)
    );

    wht_queue #(.W(QW)) u_queue (
        .i_clk, .i_rst_n, .i_push(f_valid), .i_data({f_dx, f_dy, f_tag}),
        .o_valid(q_valid), .o_data(q_data)
    );
    assign q_tag = q_data[$bits(t_tag)-1:0];

    wht_cordic #(.DW(DW), .ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .i_clk, .i_rst_n, .i_valid(q_valid),
        .i_dx(q_data[QW-1 -: DW]), .i_dy(q_data[QW-DW-1 -: DW]), .i_tag(q_tag),
        .o_valid(o_done), .o_heading(o_heading), .o_slot(o_slot),
        .o_written(o_written), .o_last(o_last_out)
    );
endmodule

// ===== src/wht_front.sv =====
// Front end: forms 8*(target - curve point), tests distance and gating.
// Depends on wht_pkg. Three registered stages, one request per cycle.
module wht_front import wht_pkg::*; #(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF,
    parameter int DW            = COORD_BITS + 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_px, i_py, i_hx, i_hy,
    input  logic signed [COORD_BITS-1:0] i_nx, i_ny, i_tx, i_ty,
    input  logic [7:0]                   i_idx,
    input  logic                         i_last,
    input  logic                         i_rotate_busy,
    input  logic [1:0]                   i_mode,
    input  logic [15:0]                  i_min_dist,
    output logic                         o_valid,
    output logic signed [DW-1:0]         o_dx,
    output logic signed [DW-1:0]         o_dy,
    output t_tag                         o_tag
);
    // 8*min_dist stays below 2^19, so only small components need squaring
    localparam int LW  = 19;
    localparam int SQW = 2 * LW;

    // stage 1: 8D = 8t - p - 6h - n
    logic                  r_v1;
    logic signed [DW-1:0]  r_dx1, r_dy1;
    logic [7:0]            r_idx1;
    logic                  r_last1;
    logic signed [DW-1:0]  n_dx1, n_dy1;
    always_comb begin
        n_dx1 = (DW'(i_tx) <<< 3) - DW'(i_px) - (DW'(i_hx) <<< 2)
              - (DW'(i_hx) <<< 1) - DW'(i_nx);
        n_dy1 = (DW'(i_ty) <<< 3) - DW'(i_py) - (DW'(i_hy) <<< 2)
              - (DW'(i_hy) <<< 1) - DW'(i_ny);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_dx1 <= n_dx1; r_dy1 <= n_dy1; r_idx1 <= i_idx; r_last1 <= i_last;
    end

    // stage 2: range test against 8*min_dist, squares of the low bits
    logic                  r_v2;
    logic signed [DW-1:0]  r_dx2, r_dy2;
    logic [SQW-1:0]        r_sqx, r_sqy;
    logic                  r_inx, r_iny;
    logic [7:0]            r_idx2;
    logic                  r_last2;
    logic [DW-1:0]         ax, ay;
    logic [LW-1:0]         lim;
    assign ax  = r_dx1[DW-1] ? DW'(-r_dx1) : DW'(r_dx1);
    assign ay  = r_dy1[DW-1] ? DW'(-r_dy1) : DW'(r_dy1);
    assign lim = {i_min_dist, 3'b000};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_dx2 <= r_dx1; r_dy2 <= r_dy1; r_idx2 <= r_idx1; r_last2 <= r_last1;
        r_inx <= ax < DW'(lim);
        r_iny <= ay < DW'(lim);
        r_sqx <= SQW'(ax[LW-1:0]) * SQW'(ax[LW-1:0]);
        r_sqy <= SQW'(ay[LW-1:0]) * SQW'(ay[LW-1:0]);
    end

    // stage 3: compare against (8*min_dist)^2 and apply the gating
    logic [SQW:0] sum;
    logic [37:0]  lim2;
    logic         near, ok;
    assign lim2 = 38'(i_min_dist) * 38'(i_min_dist) * 38'd64;
    assign sum  = (SQW+1)'(r_sqx) + (SQW+1)'(r_sqy);
    assign near = r_inx && r_iny && ((SQW+1)'(lim2) > sum);
    assign ok   = !i_rotate_busy && (i_mode == MODE_HEADING) && !near
                && (32'(r_idx2) < 32'(MAX_WAYPOINTS));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v2;
        end
        o_dx <= r_dx2; o_dy <= r_dy2;
        o_tag <= '{ok: ok, slot: r_idx2, last: r_last2};
    end
endmodule

// ===== src/wht_queue.sv =====
// Short FIFO between the classifier front end and the CORDIC back end.
// Depends on wht_pkg. Memory read data registered at the output side.
module wht_queue import wht_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    // the back end never stalls, so entries drain the cycle after push
    logic [W-1:0] r_mem [4];
    logic [1:0]   r_wp, r_rp;
    logic [2:0]   r_cnt;
    logic         pop;
    assign pop = r_cnt != 3'd0;
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        o_data <= r_mem[r_rp];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; o_valid <= 1'b0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(pop);
            o_valid <= pop;
        end
    end
endmodule

// ===== src/wht_cordic.sv =====
// Back end: normalizes the vector and runs a pipelined CORDIC vectoring unit.
// Depends on wht_pkg and the assertion macro header.
`include "waypoint_heading_to_target_unit_macros.svh"
module wht_cordic import wht_pkg::*; #(
    parameter int DW         = 37,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [DW-1:0] i_dx,
    input  logic signed [DW-1:0] i_dy,
    input  t_tag                 i_tag,
    output logic                 o_valid,
    output logic [15:0]          o_heading,
    output logic [7:0]           o_slot,
    output logic                 o_written,
    output logic                 o_last
);
    localparam int NS  = CORDIC_STEPS;
    localparam int LZW = $clog2(CW);

    // normalization: shift left until max(|x|,|y|) reaches 2^51
    logic signed [CW-1:0] sx, sy, ux, uy;
    logic [CW-1:0]        ax, ay, mx;
    logic [LZW-1:0]       sh;
    logic                 zero;
    always_comb begin
        sx = CW'(i_dx); sy = CW'(i_dy);
        ax = sx[CW-1] ? CW'(-sx) : CW'(sx);
        ay = sy[CW-1] ? CW'(-sy) : CW'(sy);
        mx = ax | ay;
        zero = (mx == '0);
        sh = '0;
        for (int b = 0; b <= NORM_EXP; b++) begin
            if (mx[b]) sh = LZW'(NORM_EXP - b);
        end
        ux = sx <<< sh;
        uy = sy <<< sh;
    end

    // half-turn pre-rotation for negative x
    logic signed [CW-1:0] r_x [NS+1];
    logic signed [CW-1:0] r_y [NS+1];
    logic [ZW-1:0]        r_z [NS+1];
    logic                 r_v [NS+1];
    logic                 r_zero [NS+1];
    t_tag                 r_tag [NS+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_x[0] <= ux[CW-1] ? CW'(-ux) : ux;
        r_y[0] <= ux[CW-1] ? CW'(-uy) : uy;
        r_z[0] <= ux[CW-1] ? 32'h8000_0000 : '0;
        r_zero[0] <= zero;
        r_tag[0] <= i_tag;
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < NS; i++) begin : g_rot
        logic signed [CW-1:0] xs, ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
            if (!r_y[i][CW-1]) begin
                r_x[i+1] <= r_x[i] + ys;
                r_y[i+1] <= r_y[i] - xs;
                r_z[i+1] <= r_z[i] + atan_turns(i);
            end else begin
                r_x[i+1] <= r_x[i] - ys;
                r_y[i+1] <= r_y[i] + xs;
                r_z[i+1] <= r_z[i] - atan_turns(i);
            end
            r_zero[i+1] <= r_zero[i];
            r_tag[i+1]  <= r_tag[i];
        end
    end

    // quarter-turn offset, rounding to the output angle width
    logic [ZW-1:0]         z, zr;
    logic [ANGLE_BITS-1:0] a;
    always_comb begin
        z  = (r_zero[NS] ? '0 : r_z[NS]) - 32'h4000_0000;
        zr = z + (32'd1 << (31 - ANGLE_BITS));
        a  = zr[ZW-1 -: ANGLE_BITS];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[NS];
        end
        o_heading <= r_tag[NS].ok ? 16'(signed'(a)) : 16'd0;
        o_slot    <= r_tag[NS].slot;
        o_written <= r_tag[NS].ok;
        o_last    <= r_tag[NS].last;
    end

    `WHT_ASSERT_NXT(a_valid_flow, i_clk, i_rst_n, r_v[NS], o_valid)
    `WHT_ASSERT_NXT(a_no_spurious, i_clk, i_rst_n, !r_v[NS], !o_valid)
    `WHT_ASSERT_IMP(a_idle_heading, i_clk, i_rst_n, o_valid && !o_written, o_heading == 16'd0)
endmodule

// ===== tb/sv/tb_heading_checker.sv =====
// Scoreboard for the waypoint heading unit: predicts each heading from the
// accepted requests and register writes, and compares the results. Uses wht_pkg.
module tb_heading_checker import wht_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] prev_x, prev_y, here_x, here_y,
    input  logic signed [31:0] next_x, next_y, target_x, target_y,
    input  logic [7:0]         wp_index,
    input  logic               last_in,
    input  logic               cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic               done,
    input  logic signed [15:0] heading,
    input  logic [7:0]         slot,
    input  logic               written,
    input  logic               last_out,
    output int                 n_errors,
    output int                 n_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] heading;
        logic [7:0]  slot;
        logic        written;
        logic        last;
    } t_heading;

    t_heading   expected_headings[$];
    logic       busy_rot;
    logic [1:0] move_mode;
    logic [15:0] min_dist;

    // arctangent steps in units of 2^32 per turn
    localparam logic [31:0] ATAN_STEP [0:29] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    function automatic longint iabs(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // vectoring rotation: angle of (x,y) as a 32-bit turn fraction
    function automatic logic [31:0] vector_angle(longint x, longint y);
        logic [31:0] z;
        longint xs, ys;
        longint lim;
        int k;
        z = '0;
        lim = longint'(1) <<< 51;
        if (x == 0 && y == 0) return '0;
        k = 0;
        while (k < 64 && iabs(x) < lim && iabs(y) < lim) begin
            x = x * 2;
            y = y * 2;
            k++;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < 30; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
        end
        return z;
    endfunction

    function automatic t_heading predict_heading();
        t_heading r;
        longint dx8, dy8, lim;
        logic near, ok;
        logic [31:0] z, a;
        dx8 = 8 * longint'(target_x) - (longint'(prev_x) + 6 * longint'(here_x)
              + longint'(next_x));
        dy8 = 8 * longint'(target_y) - (longint'(prev_y) + 6 * longint'(here_y)
              + longint'(next_y));
        lim = 8 * longint'(min_dist);
        near = 1'b0;
        if (lim > 0 && iabs(dx8) < lim && iabs(dy8) < lim)
            near = (dx8 * dx8 + dy8 * dy8) < lim * lim;
        ok = !busy_rot && move_mode == MODE_HEADING && !near;
        r.heading = '0;
        if (ok) begin
            z = vector_angle(dx8, dy8) - 32'h4000_0000;
            a = (z + 32'h0000_8000) >> 16;
            r.heading = a[15:0];
        end
        r.slot = wp_index;
        r.written = ok;
        r.last = last_in;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        n_errors++;
    endtask

    assign n_pending = expected_headings.size();

    always @(posedge i_clk) begin
        t_heading e;
        if (!i_rst_n) begin
            n_errors   = 0;
            busy_rot  <= 1'b0;
            move_mode <= 2'd0;
            min_dist  <= MIN_DIST_RESET;
        end else begin
            // register writes
            if (cfg_we) begin
                case (cfg_idx)
                    REG_ROTATE_BUSY:   busy_rot  <= cfg_data[0];
                    REG_MOVEMENT_MODE: move_mode <= cfg_data[1:0];
                    REG_MIN_DISTANCE:  min_dist  <= cfg_data;
                    default: ;
                endcase
            end
            // accepted request
            if (start && !busy) expected_headings.push_back(predict_heading());
            // result compare
            if (done) begin
                if (expected_headings.size() == 0) begin
                    report_mismatch("unexpected result", heading, 16'h0);
                end else begin
                    e = expected_headings.pop_front();
                    if (heading !== e.heading) report_mismatch("heading", heading, e.heading);
                    if (slot !== e.slot) report_mismatch("slot", 16'(slot), 16'(e.slot));
                    if (written !== e.written)
                        report_mismatch("written", 16'(written), 16'(e.written));
                    if (last_out !== e.last)
                        report_mismatch("last", 16'(last_out), 16'(e.last));
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb_top.sv =====
// Stimulus and verdict for the waypoint heading unit.
// Depends on wht_pkg, the unit itself and tb_heading_checker.
module tb_top import wht_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 300000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] px = '0, py = '0, hx = '0, hy = '0;
    logic signed [31:0] nx = '0, ny = '0, tx = '0, ty = '0;
    logic [7:0] wp_index = '0;
    logic last_in = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic done, written, last_out;
    logic signed [15:0] heading;
    logic [7:0] slot;
    int n_errors, n_pending;
    int cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    waypoint_heading_to_target_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_prev_x(px), .i_prev_y(py), .i_here_x(hx), .i_here_y(hy),
        .i_next_x(nx), .i_next_y(ny), .i_target_x(tx), .i_target_y(ty),
        .i_waypoint_index(wp_index), .i_last_in(last_in),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_done(done), .o_heading(heading), .o_slot(slot),
        .o_written(written), .o_last_out(last_out)
    );

    tb_heading_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .prev_x(px), .prev_y(py), .here_x(hx), .here_y(hy),
        .next_x(nx), .next_y(ny), .target_x(tx), .target_y(ty),
        .wp_index(wp_index), .last_in(last_in),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .done(done), .heading(heading), .slot(slot), .written(written),
        .last_out(last_out), .n_errors(n_errors), .n_pending(n_pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // register write, only while nothing is in flight
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
        start <= 1'b0;
        while (n_pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(logic rb, logic [1:0] mode, logic [15:0] md);
        write_reg(REG_ROTATE_BUSY, {15'd0, rb});
        write_reg(REG_MOVEMENT_MODE, {14'd0, mode});
        write_reg(REG_MIN_DISTANCE, md);
    endtask

    // one request; start stays high until the next step decides
    task automatic send_request(logic signed [31:0] a, b, c, d, e, f, g, h);
        px <= a; py <= b; hx <= c; hy <= d;
        nx <= e; ny <= f; tx <= g; ty <= h;
        wp_index <= 8'($urandom);
        last_in  <= 1'($urandom);
        start    <= 1'b1;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_coord(logic signed [31:0] base);
        case ($urandom_range(0, 7))
            0: return 32'($urandom);
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return base + 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
            default: return base + 32'($urandom_range(0, 8192)) - 32'sd4096;
        endcase
    endfunction

    task automatic random_burst(int count);
        logic signed [31:0] bx, by;
        int left;
        left = count;
        while (left > 0) begin
            for (int k = $urandom_range(1, 20); k > 0 && left > 0; k--) begin
                bx = 32'($urandom) >>> $urandom_range(0, 31);
                by = 32'($urandom) >>> $urandom_range(0, 31);
                send_request(pick_coord(bx), pick_coord(by), pick_coord(bx),
                             pick_coord(by), pick_coord(bx), pick_coord(by),
                             pick_coord(bx), pick_coord(by));
                left--;
            end
            // gap, sometimes none
            if ($urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: defaults (mode 0), nothing written
        send_request(0, 0, 0, 0, 0, 0, 32'sd4096, 0);
        set_regs(1'b0, MODE_HEADING, 16'd26);
        // axes, negative x, extremes
        send_request(0, 0, 0, 0, 0, 0, 32'sd4096, 0);
        send_request(0, 0, 0, 0, 0, 0, -32'sd4096, 0);
        send_request(0, 0, 0, 0, 0, 0, 0, 32'sd4096);
        send_request(0, 0, 0, 0, 0, 0, 0, -32'sd4096);
        send_request(0, 0, 0, 0, 0, 0, -32'sd4096, -32'sd1);
        send_request(0, 0, 0, 0, 0, 0, -32'sd4096, 32'sd1);
        send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        // just inside and just outside the distance threshold
        send_request(0, 0, 0, 0, 0, 0, 32'sd25, 0);
        send_request(0, 0, 0, 0, 0, 0, 32'sd26, 0);
        send_request(0, 0, 0, 0, 0, 0, 32'sd18, 32'sd18);
        send_request(0, 0, 0, 0, 0, 0, 32'sd19, 32'sd19);
        send_request(8, 0, 0, 0, 0, 0, 32'sd1, 0);
        // zero vector with zero threshold
        write_reg(REG_MIN_DISTANCE, 16'd0);
        send_request(32'sd100, 32'sd7, 32'sd100, 32'sd7, 32'sd100, 32'sd7, 32'sd100, 32'sd7);
        send_request(0, 0, 0, 0, 0, 0, 32'sd1, 0);
        // rotation in progress, unused register index
        write_reg(REG_ROTATE_BUSY, 16'd1);
        send_request(0, 0, 0, 0, 0, 0, 32'sd4096, 32'sd4096);
        write_reg(2'd3, 16'hffff);
        send_request(0, 0, 0, 0, 0, 0, 32'sd4096, 32'sd4096);

        // random phases over several settings
        set_regs(1'b0, MODE_HEADING, 16'd26);
        random_burst(200);
        set_regs(1'b0, MODE_HEADING, 16'd0);
        random_burst(100);
        set_regs(1'b0, MODE_HEADING, 16'hffff);
        random_burst(100);
        set_regs(1'b0, MODE_HEADING, 16'($urandom));
        random_burst(200);
        set_regs(1'b1, MODE_HEADING, 16'($urandom_range(0, 4096)));
        random_burst(50);
        set_regs(1'b0, 2'd0, 16'd26);
        random_burst(40);
        set_regs(1'b0, 2'd2, 16'd26);
        random_burst(40);
        set_regs(1'b0, 2'd3, 16'd26);
        random_burst(40);
        set_regs(1'b0, MODE_HEADING, 16'($urandom_range(0, 2048)));
        random_burst(150);

        // drain
        start <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
